// ===== rtl/core/fcw_pkg.sv =====
// Shared constants, types and codes for the fan curve block.
package fcw_pkg;

  // Window depths: taps of the heat-up (min) and cool-down (max) cell rows.
  localparam int unsigned HEAT_DEPTH = 10;
  localparam int unsigned COOL_DEPTH = 10;
  localparam int unsigned NUM_POINTS = 5;

  localparam int unsigned DUTY_W = 8;
  localparam int unsigned TEMP_W = 8;
  localparam int unsigned POINT_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = POINT_W;

  localparam int unsigned MAX_DEPTH = (HEAT_DEPTH > COOL_DEPTH) ? HEAT_DEPTH : COOL_DEPTH;
  localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);

  typedef logic [NUM_POINTS-1:0][POINT_W-1:0] point_arr_t;

  // Reset curve: 70C/102, 75C/128, 80C/153, 85C/166, 90C/166.
  localparam point_arr_t POINT_RESET = {16'd23206, 16'd21926, 16'd20633, 16'd19328, 16'd18022};
  localparam logic [DUTY_W-1:0] ERROR_DUTY_RESET = 8'd128;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT0     = 3'd0,
    REG_POINT1     = 3'd1,
    REG_POINT2     = 3'd2,
    REG_POINT3     = 3'd3,
    REG_POINT4     = 3'd4,
    REG_ERROR_DUTY = 3'd5,
    REG_MAX_DUTY   = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HSHIFT,
    S_HSWEEP,
    S_CSHIFT,
    S_CSWEEP,
    S_DONE
  } state_e;

  // Control into one window cell.
  typedef struct packed {
    logic shift;   // take the neighbor's entry
    logic is_max;  // reduce with max instead of min
  } cell_ctrl_t;

endpackage

// ===== rtl/core/fcw_if.sv =====
// Valid/ready channel interfaces for tick beats and result beats.
interface fcw_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fcw_pkg::TEMP_W-1:0]    temp_reading;
  logic                                 read_ok;
  logic                                 powered_on;

  modport source (output valid, output temp_reading, output read_ok, output powered_on,
                  input ready);
  modport sink   (input valid, input temp_reading, input read_ok, input powered_on,
                  output ready);
endinterface

interface fcw_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [fcw_pkg::DUTY_W-1:0]           fan_duty;
  logic                                 duty_changed;
  logic signed [fcw_pkg::TEMP_W-1:0]    reported_temp;

  modport source (output valid, output fan_duty, output duty_changed, output reported_temp,
                  input ready);
  modport sink   (input valid, input fan_duty, input duty_changed, input reported_temp,
                  output ready);
endinterface

// ===== rtl/core/fan_curve_with_hysteresis_windows.sv =====
// Top level: fan duty from a step curve through heat-up and cool-down windows.
//
// Usage:
//   in_i   - one beat per tick: temp_reading (signed C), read_ok, powered_on.
//   out_o  - one beat per tick: fan_duty, duty_changed, reported_temp.
//   cfg_*  - write-only register port; index 0..4 curve points, 5 error duty,
//            6 max duty. Write only while no tick is in flight.
// Timing:
//   The two cell rows are swept one tap per cycle: the running min walks
//   the heat row, then the running max walks the cool row, so one tick is
//   in work at a time; a new input beat is taken only in the idle state.
// Reset:
//   Both windows and the last duty clear to zero, registers take their
//   defaults; no clearing pass is needed.
// Backpressure:
//   Results sit in an output register; the next tick is accepted while a
//   result waits, and its result waits in the final state until the output
//   register frees up.
module fan_curve_with_hysteresis_windows (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  fcw_in_if.sink                             in_i,
  fcw_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [fcw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fcw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned HD = fcw_pkg::HEAT_DEPTH;
  localparam int unsigned CD = fcw_pkg::COOL_DEPTH;
  localparam int unsigned DW = fcw_pkg::DUTY_W;
  localparam int unsigned CW = fcw_pkg::CNT_W;

  // ---------------- configuration registers ----------------
  fcw_pkg::point_arr_t points_q, points_d;
  logic [DW-1:0]       err_duty_q, err_duty_d;
  logic [DW-1:0]       max_duty_q, max_duty_d;

  always_comb begin
    points_d   = points_q;
    err_duty_d = err_duty_q;
    max_duty_d = max_duty_q;
    if (cfg_we_i) begin
      case (fcw_pkg::cfg_reg_e'(cfg_idx_i))
        fcw_pkg::REG_POINT0:     points_d[0] = cfg_wdata_i;
        fcw_pkg::REG_POINT1:     points_d[1] = cfg_wdata_i;
        fcw_pkg::REG_POINT2:     points_d[2] = cfg_wdata_i;
        fcw_pkg::REG_POINT3:     points_d[3] = cfg_wdata_i;
        fcw_pkg::REG_POINT4:     points_d[4] = cfg_wdata_i;
        fcw_pkg::REG_ERROR_DUTY: err_duty_d = cfg_wdata_i[DW-1:0];
        fcw_pkg::REG_MAX_DUTY:   max_duty_d = cfg_wdata_i[DW-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q   <= fcw_pkg::POINT_RESET;
      err_duty_q <= fcw_pkg::ERROR_DUTY_RESET;
      max_duty_q <= fcw_pkg::MAX_DUTY_RESET;
    end else begin
      points_q   <= points_d;
      err_duty_q <= err_duty_d;
      max_duty_q <= max_duty_d;
    end
  end

  // ---------------- request stage ----------------
  logic [DW-1:0]                    curve_duty;
  logic [DW-1:0]                    req_d, req_q;
  logic signed [fcw_pkg::TEMP_W-1:0] rep_d, rep_q;
  logic                             in_fire;

  fcw_curve u_curve (
    .points_i   (points_q),
    .max_duty_i (max_duty_q),
    .temp_i     (in_i.temp_reading),
    .duty_o     (curve_duty)
  );

  assign in_fire = in_i.valid && in_i.ready;

  // Off: duty 0; read error: error duty, temperature reported as 0.
  always_comb begin
    req_d = '0;
    rep_d = '0;
    if (in_i.powered_on) begin
      if (in_i.read_ok) begin
        req_d = curve_duty;
        rep_d = in_i.temp_reading;
      end else begin
        req_d = err_duty_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
      rep_q <= rep_d;
    end
  end

  // ---------------- sequencer ----------------
  fcw_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            in_ready;
  logic            heat_shift, cool_shift, out_load;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fcw_pkg::S_IDLE:   if (in_fire) state_d = fcw_pkg::S_HSHIFT;
      fcw_pkg::S_HSHIFT: state_d = fcw_pkg::S_HSWEEP;
      fcw_pkg::S_HSWEEP: if (cnt_q == CW'(HD - 1)) state_d = fcw_pkg::S_CSHIFT;
      fcw_pkg::S_CSHIFT: state_d = fcw_pkg::S_CSWEEP;
      fcw_pkg::S_CSWEEP: if (cnt_q == CW'(CD - 1)) state_d = fcw_pkg::S_DONE;
      fcw_pkg::S_DONE:   if (!out_valid_q || out_o.ready) state_d = fcw_pkg::S_IDLE;
      default:           state_d = fcw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    heat_shift = 1'b0;
    cool_shift = 1'b0;
    out_load   = 1'b0;
    cnt_d      = '0;
    case (state_q)
      fcw_pkg::S_IDLE:   in_ready = 1'b1;
      fcw_pkg::S_HSHIFT: heat_shift = 1'b1;
      fcw_pkg::S_HSWEEP: cnt_d = (cnt_q == CW'(HD - 1)) ? '0 : cnt_q + CW'(1);
      fcw_pkg::S_CSHIFT: cool_shift = 1'b1;
      fcw_pkg::S_CSWEEP: cnt_d = (cnt_q == CW'(CD - 1)) ? '0 : cnt_q + CW'(1);
      fcw_pkg::S_DONE:   out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcw_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_i.ready = in_ready;

  // ---------------- window cell rows ----------------
  // Tap 0 holds the oldest entry; new entries enter at the top tap. After the
  // shift the row holds exactly the entries to reduce, and the running result
  // moves up one tap per cycle, seeded with the new entry.
  logic [DW-1:0] heat_val  [HD];
  logic [DW-1:0] heat_part [HD];
  logic [DW-1:0] cool_val  [CD];
  logic [DW-1:0] cool_part [CD];
  logic [DW-1:0] heat_res, cool_res;
  fcw_pkg::cell_ctrl_t heat_ctrl, cool_ctrl;

  assign heat_ctrl = '{shift: heat_shift, is_max: 1'b0};
  assign cool_ctrl = '{shift: cool_shift, is_max: 1'b1};
  assign heat_res  = heat_part[HD-1];
  assign cool_res  = cool_part[CD-1];

  for (genvar k = 0; k < HD; k++) begin : g_heat
    logic [DW-1:0] sh_in, pt_in;
    if (k == HD - 1) begin : g_top
      assign sh_in = req_q;
    end else begin : g_mid
      assign sh_in = heat_val[k+1];
    end
    if (k == 0) begin : g_seed
      assign pt_in = req_q;
    end else begin : g_link
      assign pt_in = heat_part[k-1];
    end
    fcw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (heat_ctrl),
      .shift_i (sh_in),
      .val_o   (heat_val[k]),
      .part_i  (pt_in),
      .part_o  (heat_part[k])
    );
  end

  for (genvar k = 0; k < CD; k++) begin : g_cool
    logic [DW-1:0] sh_in, pt_in;
    if (k == CD - 1) begin : g_top
      assign sh_in = heat_res;
    end else begin : g_mid
      assign sh_in = cool_val[k+1];
    end
    if (k == 0) begin : g_seed
      assign pt_in = heat_res;
    end else begin : g_link
      assign pt_in = cool_part[k-1];
    end
    fcw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cool_ctrl),
      .shift_i (sh_in),
      .val_o   (cool_val[k]),
      .part_i  (pt_in),
      .part_o  (cool_part[k])
    );
  end

  // ---------------- output register ----------------
  logic [DW-1:0]                     last_q;
  logic [DW-1:0]                     pwm_q;
  logic                              chg_q;
  logic signed [fcw_pkg::TEMP_W-1:0] rep_out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (out_load) begin
        last_q <= cool_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pwm_q     <= cool_res;
      chg_q     <= (cool_res != last_q);
      rep_out_q <= rep_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fan_duty      = pwm_q;
  assign out_o.duty_changed  = chg_q;
  assign out_o.reported_temp = rep_out_q;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == fcw_pkg::S_HSHIFT)
    else $error("accepted beat did not start the heat shift");

  a_off_reports_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.powered_on |=> rep_q == '0 && req_q == '0)
    else $error("powered-off tick did not request zero");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> chg_q == (pwm_q != $past(last_q)))
    else $error("duty_changed disagrees with the previous duty");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_o.ready)
    else $error("result loaded over a pending beat");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fcw_pkg::S_HSWEEP |-> cnt_q < CW'(HD))
    else $error("heat sweep counter overran");
`endif

endmodule

// ===== rtl/core/fcw_cell.sv =====
// One window tap: holds an entry and folds it into the running min/max.
module fcw_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fcw_pkg::cell_ctrl_t          ctrl_i,
  input  logic [fcw_pkg::DUTY_W-1:0]   shift_i,
  output logic [fcw_pkg::DUTY_W-1:0]   val_o,
  input  logic [fcw_pkg::DUTY_W-1:0]   part_i,
  output logic [fcw_pkg::DUTY_W-1:0]   part_o
);

  logic [fcw_pkg::DUTY_W-1:0] val_q, val_d;
  logic [fcw_pkg::DUTY_W-1:0] part_q, part_d;

  always_comb begin
    val_d = ctrl_i.shift ? shift_i : val_q;
    if (ctrl_i.is_max) begin
      part_d = (val_q > part_i) ? val_q : part_i;
    end else begin
      part_d = (val_q < part_i) ? val_q : part_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
  end

  assign val_o  = val_q;
  assign part_o = part_q;

endmodule

// ===== rtl/core/fcw_curve.sv =====
// Five-point step curve lookup on a signed temperature.
module fcw_curve (
  input  fcw_pkg::point_arr_t                points_i,
  input  logic [fcw_pkg::DUTY_W-1:0]         max_duty_i,
  input  logic signed [fcw_pkg::TEMP_W-1:0]  temp_i,
  output logic [fcw_pkg::DUTY_W-1:0]         duty_o
);

  logic                              done;
  logic [fcw_pkg::DUTY_W-1:0]        prev;
  logic signed [fcw_pkg::TEMP_W-1:0] pt;

  // First point at or above the reading decides; scan in list order.
  always_comb begin
    duty_o = max_duty_i;
    done   = 1'b0;
    prev   = '0;
    pt     = '0;
    for (int i = 0; i < fcw_pkg::NUM_POINTS; i++) begin
      pt = signed'(points_i[i][fcw_pkg::POINT_W-1 -: fcw_pkg::TEMP_W]);
      if (!done) begin
        if (temp_i == pt) begin
          duty_o = points_i[i][fcw_pkg::DUTY_W-1:0];
          done   = 1'b1;
        end else if (temp_i < pt) begin
          duty_o = prev;
          done   = 1'b1;
        end
      end
      prev = points_i[i][fcw_pkg::DUTY_W-1:0];
    end
  end

endmodule

// ===== dv/fan_curve_with_hysteresis_windows_tb.sv =====
// Testbench for the fan curve block: directed and random ticks checked against a scoreboard.
module fan_curve_with_hysteresis_windows_tb;
  import fcw_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 7;
  // One tick is in flight at a time; this is its full sweep through both rows.
  localparam int unsigned TICK_LATENCY = HEAT_DEPTH + COOL_DEPTH + 3;
  // Long receiver hold-off: many tick times, so the block fills and stalls its input.
  localparam int unsigned LONG_HOLD    = 400;
  // Watchdog, in time units: several times the slowest legal run.
  localparam int unsigned RUN_LIMIT    = 5_000_000;
  // Only index the 3-bit port can reach beyond the register file.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic [DUTY_W-1:0]        duty_t;
  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef struct {
    temp_t temp;
    logic  read_ok;
    logic  powered_on;
  } tick_t;

  typedef struct {
    duty_t fan_duty;
    logic  duty_changed;
    temp_t reported_temp;
  } duty_result_t;

  // Receiver stall patterns.
  typedef enum int unsigned {
    RX_OPEN,    // always ready
    RX_COIN,    // ready on a coin flip
    RX_SPARSE,  // ready about one cycle in four
    RX_BURSTY   // ready while seg_left mod 8 is below 5
  } rx_mode_e;

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of the curve, registers and both windows. Each accepted
  // tick advances the windows and queues the duty beat it should produce.
  // ---------------------------------------------------------------------------
  class fan_duty_scoreboard;
    logic [POINT_W-1:0] curve[NUM_POINTS];
    duty_t              err_duty;
    duty_t              top_duty;
    duty_t              heat_win[HEAT_DEPTH];
    duty_t              cool_win[COOL_DEPTH];
    duty_t              last_pwm;
    duty_result_t       due_q[$];
    int unsigned        mismatches;

    function new();
      for (int i = 0; i < NUM_POINTS; i++) curve[i] = POINT_RESET[i];
      err_duty = ERROR_DUTY_RESET;
      top_duty = MAX_DUTY_RESET;
      foreach (heat_win[i]) heat_win[i] = '0;
      foreach (cool_win[i]) cool_win[i] = '0;
      last_pwm   = '0;
      mismatches = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < NUM_POINTS) curve[idx] = data;
      else if (idx == REG_ERROR_DUTY) err_duty = data[DUTY_W-1:0];
      else if (idx == REG_MAX_DUTY) top_duty = data[DUTY_W-1:0];
    endfunction

    // Step curve: scan in index order, first equal or first greater point wins.
    function duty_t curve_duty(temp_t t);
      temp_t pt;
      for (int i = 0; i < NUM_POINTS; i++) begin
        pt = curve[i][POINT_W-1:DUTY_W];
        if (t == pt) return curve[i][DUTY_W-1:0];
        if (t < pt) begin
          if (i == 0) return '0;
          return curve[i-1][DUTY_W-1:0];
        end
      end
      return top_duty;
    endfunction

    function void note_tick(tick_t t);
      duty_t        req;
      duty_t        heat_out;
      duty_t        cool_out;
      duty_result_t r;
      req             = '0;
      r.reported_temp = '0;
      if (t.powered_on && t.read_ok) begin
        req             = curve_duty(t.temp);
        r.reported_temp = t.temp;
      end else if (t.powered_on) begin
        req = err_duty;
      end
      // heat-up: min over the new request and the surviving entries
      heat_out = req;
      for (int i = 0; i < HEAT_DEPTH - 1; i++) begin
        heat_win[i] = heat_win[i+1];
        if (heat_win[i] < heat_out) heat_out = heat_win[i];
      end
      heat_win[HEAT_DEPTH-1] = req;
      // cool-down: max over the heat-up output and the surviving entries
      cool_out = heat_out;
      for (int i = 0; i < COOL_DEPTH - 1; i++) begin
        cool_win[i] = cool_win[i+1];
        if (cool_win[i] > cool_out) cool_out = cool_win[i];
      end
      cool_win[COOL_DEPTH-1] = heat_out;
      r.fan_duty     = cool_out;
      r.duty_changed = (cool_out != last_pwm);
      last_pwm       = cool_out;
      due_q.push_back(r);
    endfunction

    function void check_result(duty_result_t got);
      duty_result_t want;
      if (due_q.size() == 0) begin
        $error("duty beat with no tick pending: fan_duty %0d", got.fan_duty);
        mismatches++;
        return;
      end
      want = due_q.pop_front();
      if (got.fan_duty !== want.fan_duty) begin
        $error("fan_duty: expected %0d, got %0d", want.fan_duty, got.fan_duty);
        mismatches++;
      end
      if (got.duty_changed !== want.duty_changed) begin
        $error("duty_changed: expected %0b, got %0b", want.duty_changed, got.duty_changed);
        mismatches++;
      end
      if (got.reported_temp !== want.reported_temp) begin
        $error("reported_temp: expected %0d, got %0d", want.reported_temp,
               got.reported_temp);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fcw_in_if  tick_ch ();
  fcw_out_if duty_ch ();

  fan_curve_with_hysteresis_windows uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (tick_ch),
    .out_o      (duty_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  fan_duty_scoreboard duty_sb = new();

  int unsigned burst_left  = 0;
  bit          rx_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the edge, before any NBA update lands.
  // Result beat is checked first; it always belongs to an earlier tick.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (duty_ch.valid && duty_ch.ready)
        duty_sb.check_result('{duty_ch.fan_duty, duty_ch.duty_changed, duty_ch.reported_temp});
      if (tick_ch.valid && tick_ch.ready)
        duty_sb.note_tick('{tick_ch.temp_reading, tick_ch.read_ok, tick_ch.powered_on});
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: exactly one ready update per cycle. Stall pattern is redrawn every
  // segment; a pending long-hold request wins over the pattern.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned seg_left;
    rx_mode_e    rx_mode;
    hold_left = 0;
    seg_left  = 0;
    rx_mode   = RX_OPEN;
    duty_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        duty_ch.ready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = LONG_HOLD - 1;
        duty_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          rx_mode  = rx_mode_e'($urandom_range(0, 3));
        end
        seg_left--;
        case (rx_mode)
          RX_OPEN:   duty_ch.ready <= 1'b1;
          RX_COIN:   duty_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: duty_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   duty_ch.ready <= ((seg_left % 8) < 5);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // One register write per edge; caller drops the enable after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    duty_sb.apply_reg(idx, data);
  endtask

  // Full register set, plus a stray write to the unused index that must not land.
  task automatic load_curve(point_arr_t pts, duty_t err, duty_t top);
    write_reg(REG_POINT0, pts[0]);
    write_reg(REG_POINT1, pts[1]);
    write_reg(REG_POINT2, pts[2]);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_POINT3, pts[3]);
    write_reg(REG_POINT4, pts[4]);
    write_reg(REG_ERROR_DUTY, CFG_DATA_W'(err));
    write_reg(REG_MAX_DUTY, CFG_DATA_W'(top));
    cfg_we <= 1'b0;
  endtask

  // Sender works in bursts; a gap of random length opens each new burst.
  // 'eager' skips the gap logic so the block sees back-to-back offers.
  task automatic send_tick(tick_t t, bit eager);
    int unsigned gap;
    gap = 0;
    if (!eager) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
        gap = $urandom_range(1, 30);
      end
      burst_left--;
    end
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.temp_reading <= t.temp;
    tick_ch.read_ok      <= t.read_ok;
    tick_ch.powered_on   <= t.powered_on;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // Stop offering and wait out every outstanding duty beat.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (duty_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic tick_t make_tick(temp_t temp, logic ok, logic on);
    tick_t t;
    t.temp       = temp;
    t.read_ok    = ok;
    t.powered_on = on;
    return t;
  endfunction

  // Random ticks in runs: each run hovers around one curve point (or a random
  // spot) so the windows see sustained levels and real rise/fall edges. Runs
  // are mostly good reads, some read failures and power-off stretches, with
  // sprinkled noise beats.
  task automatic random_ticks(int unsigned count);
    int unsigned run_left;
    int unsigned kind;
    temp_t       base;
    tick_t       t;
    run_left = 0;
    kind     = 0;
    base     = '0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 24);
        kind     = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) base = TEMP_W'($urandom);
        else base = duty_sb.curve[$urandom_range(0, NUM_POINTS-1)][POINT_W-1:DUTY_W];
      end
      run_left--;
      if ($urandom_range(0, 7) == 0) base = TEMP_W'(base + $urandom_range(0, 2) - 1);
      t.temp       = TEMP_W'(base + $urandom_range(0, 4) - 2);
      t.read_ok    = (kind < 14) ? 1'b1 : (kind < 17) ? 1'b0 : 1'($urandom_range(0, 1));
      t.powered_on = (kind < 17);
      if ($urandom_range(0, 15) == 0)
        t = make_tick(TEMP_W'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      // occasional full drain mid-stream
      if ($urandom_range(0, 99) == 0) settle();
      send_tick(t, 1'b0);
    end
  endtask

  // Receiver holds off for a long stretch while ticks keep coming back-to-back.
  task automatic backlog_burst();
    rx_hold_req = 1'b1;
    for (int n = 0; n < 20; n++)
      send_tick(make_tick(TEMP_W'($urandom), 1'($urandom_range(0, 1)), 1'b1), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    point_arr_t pts;
    byte        sorted_t[$];

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_wdata            <= '0;
    tick_ch.valid        <= 1'b0;
    tick_ch.temp_reading <= '0;
    tick_ch.read_ok      <= 1'b0;
    tick_ch.powered_on   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset curve (70/75/80/85/90 C): power off, read failure,
    // both, field extremes, below the first point, exact hits, between
    // points, above every point.
    send_tick(make_tick(8'sd80, 1'b1, 1'b0), 1'b0);
    send_tick(make_tick(8'sd55, 1'b0, 1'b1), 1'b0);
    send_tick(make_tick(-8'sd1, 1'b0, 1'b0), 1'b0);
    send_tick(make_tick(-8'sd128, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd127, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd69, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd70, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd72, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd75, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd80, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd85, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd88, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd90, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd91, 1'b1, 1'b1), 1'b0);
    send_tick(make_tick(8'sd0, 1'b1, 1'b1), 1'b0);
    // sustained hot reading: enough to fill the heat row so max duty gets out
    for (int n = 0; n < HEAT_DEPTH; n++) send_tick(make_tick(8'sd100, 1'b1, 1'b1), 1'b0);

    random_ticks(150);
    backlog_burst();
    settle();

    // Random points in random order, random error/max duty.
    for (int i = 0; i < NUM_POINTS; i++) pts[i] = POINT_W'($urandom);
    load_curve(pts, DUTY_W'($urandom), DUTY_W'($urandom));
    random_ticks(150);
    settle();

    // Extremes: -128 and 127 temps, duplicated temps, 0/255 duties, zero max/error.
    pts[0] = 16'h8000;
    pts[1] = 16'h80FF;
    pts[2] = 16'h0000;
    pts[3] = 16'h7FFF;
    pts[4] = 16'h7F00;
    load_curve(pts, 8'd0, 8'd0);
    random_ticks(150);
    settle();

    // All ones everywhere.
    for (int i = 0; i < NUM_POINTS; i++) pts[i] = '1;
    load_curve(pts, 8'hFF, 8'hFF);
    random_ticks(100);
    settle();

    // A proper ascending curve with random content.
    for (int i = 0; i < NUM_POINTS; i++) sorted_t.push_back(byte'($urandom));
    sorted_t.sort();
    for (int i = 0; i < NUM_POINTS; i++) pts[i] = {sorted_t[i], DUTY_W'($urandom)};
    load_curve(pts, DUTY_W'($urandom), DUTY_W'($urandom));
    random_ticks(150);
    settle();

    // Back to the power-on curve, with a second backlog.
    load_curve(POINT_RESET, ERROR_DUTY_RESET, MAX_DUTY_RESET);
    random_ticks(100);
    backlog_burst();
    random_ticks(50);

    settle();
    repeat (TICK_LATENCY + 5) @(posedge clk);
    if (duty_sb.mismatches == 0 && duty_sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fcw_pkg.sv
rtl/core/fcw_if.sv
rtl/core/fcw_cell.sv
rtl/core/fcw_curve.sv
rtl/core/fan_curve_with_hysteresis_windows.sv
dv/fan_curve_with_hysteresis_windows_tb.sv
